>>> design/bta_pkg.sv
// Package for the boundary-tag heap allocator.
// Holds layout constants, status codes and tag helpers; no dependencies.
package bta_pkg;

  localparam int HEAP_BYTES_DEF = 65536;
  localparam int TAG_W          = 18;
  localparam int REQ_W          = 17;
  localparam int ADDR_W         = 16;
  localparam int CHUNK_W        = 17;
  localparam int STATUS_W       = 2;
  localparam int MIN_BLOCK      = 32;
  localparam int INIT_CHUNK     = 4096;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic [TAG_W-1:0] TAG_ALLOC = 18'd1;

  // size part of a tag (alloc and spare bits cleared)
  function automatic logic [TAG_W-1:0] tag_size(input logic [TAG_W-1:0] t);
    tag_size = {t[TAG_W-1:3], 3'b000};
  endfunction

endpackage

>>> design/boundary_tag_heap_allocator.sv
// Boundary-tag heap allocator, implicit block list, first-fit placement.
// A free clears the alloc bits and merges with free neighbors; an allocate walks the blocks,
//   grows the heap when none fits, and then places.
// Throughput: one request in flight; the next is taken the cycle after its result transfer.
// Reset: synchronous; a clearing pass over all HEAP_BYTES/8 entries rebuilds the tag store
//   (prologue, epilogue, one 4096-byte free block); no item is accepted meanwhile.
// Depends on bta_pkg.
module boundary_tag_heap_allocator #(
  parameter int HEAP_BYTES = bta_pkg::HEAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // chunk_bytes register
  input  logic                         cfg_wen,
  input  logic [bta_pkg::CHUNK_W-1:0]  cfg_wdata,
  // request stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [39:0]                  s_tdata,   // [16:0] request_size, [32:17] block_address
  input  logic                         s_tuser,   // action: 0 allocate, 1 free
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata    // [15:0] result_address, [17:16] status
);
  import bta_pkg::*;

  localparam int AW    = $clog2(HEAP_BYTES);     // byte address bits
  localparam int IW    = AW - 3;                 // tag index bits
  localparam int DEPTH = HEAP_BYTES / 8;
  localparam int WW    = ((AW > TAG_W) ? AW : TAG_W) + 2;  // walk arithmetic width

  localparam logic [IW-1:0] IDX_PRO_H = IW'(1);
  localparam logic [IW-1:0] IDX_PRO_F = IW'(2);
  localparam logic [IW-1:0] IDX_FREE_H = IW'(3);
  localparam logic [IW-1:0] IDX_FREE_F = IW'((32 + INIT_CHUNK - 16) / 8);
  localparam logic [IW-1:0] IDX_EPI    = IW'((32 + INIT_CHUNK - 8) / 8);

  // sequencer states
  localparam logic [5:0] S_CLR  = 6'd0,  S_IDLE = 6'd1,  S_OUT  = 6'd2;
  localparam logic [5:0] S_F0   = 6'd3,  S_F1   = 6'd4,  S_F2   = 6'd5,  S_F3 = 6'd6;
  localparam logic [5:0] S_M0   = 6'd7,  S_M1   = 6'd8,  S_M2   = 6'd9,  S_M3 = 6'd10;
  localparam logic [5:0] S_M4   = 6'd11, S_M5   = 6'd12;
  localparam logic [5:0] S_MA0  = 6'd13, S_MA1  = 6'd14, S_MA2  = 6'd15;
  localparam logic [5:0] S_MB0  = 6'd16, S_MB1  = 6'd17, S_MB2  = 6'd18;
  localparam logic [5:0] S_MB3  = 6'd19, S_MB4  = 6'd20;
  localparam logic [5:0] S_MC0  = 6'd21, S_MC1  = 6'd22, S_MC2  = 6'd23, S_MC3 = 6'd24;
  localparam logic [5:0] S_W0   = 6'd25, S_W1   = 6'd26;
  localparam logic [5:0] S_G0   = 6'd27, S_G1   = 6'd28, S_G2   = 6'd29;
  localparam logic [5:0] S_G3   = 6'd30, S_G4   = 6'd31;
  localparam logic [5:0] S_P0   = 6'd32, S_P1   = 6'd33, S_P2   = 6'd34, S_P3 = 6'd35;
  localparam logic [5:0] S_P4   = 6'd36, S_P5   = 6'd37, S_P6   = 6'd38, S_P7 = 6'd39;
  localparam logic [5:0] S_P8   = 6'd40, S_P9   = 6'd41;

  // tag store: one write port, one registered read port
  logic [TAG_W-1:0] mem [DEPTH];
  logic [TAG_W-1:0] rdata;
  logic             we;
  logic [WW-1:0]    waddr, raddr;
  logic [TAG_W-1:0] wdata;

  logic [5:0]         state;
  logic [IW:0]        clr_cnt;
  logic [CHUNK_W-1:0] chunk_bytes;
  logic [WW-1:0]      heap_end;
  logic               from_grow, pa;
  logic [WW-1:0]      req_addr, bp, p, n;
  logic [TAG_W-1:0]   asize, csize, hs, psz, sz;
  logic [ADDR_W-1:0]  result_address;
  logic [STATUS_W-1:0] status;

  logic [WW-1:0]    rsz;      // size field of the tag just read
  logic [TAG_W-1:0] rsz_t;
  logic [WW-1:0]    heap_sum;
  logic [TAG_W:0]   ext, gsz;
  logic [IW-1:0]    clr_idx;
  logic [TAG_W-1:0] clr_val;

  assign rsz_t = tag_size(rdata);
  assign rsz   = WW'(rsz_t);

  // growth: max(block, chunk), rounded to the nearest multiple of 16 bytes
  always_comb begin
    ext = (asize > TAG_W'(chunk_bytes)) ? {1'b0, asize} : (TAG_W+1)'(chunk_bytes);
    gsz = {ext[TAG_W:4] + (TAG_W-3)'(ext[3]), 4'b0000};
    heap_sum = heap_end + WW'(gsz);
  end

  assign clr_idx = clr_cnt[IW-1:0];
  always_comb begin
    if (clr_idx == IDX_PRO_H || clr_idx == IDX_PRO_F) begin
      clr_val = TAG_W'(16) | TAG_ALLOC;
    end else if (clr_idx == IDX_FREE_H || clr_idx == IDX_FREE_F) begin
      clr_val = TAG_W'(INIT_CHUNK);
    end else if (clr_idx == IDX_EPI) begin
      clr_val = TAG_ALLOC;
    end else begin
      clr_val = '0;
    end
  end

  // memory access per state; reads land in rdata in the following cycle
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      S_CLR:  begin we = 1'b1; waddr = {{(WW-AW){1'b0}}, clr_idx, 3'b000}; wdata = clr_val; end
      S_F0:   raddr = req_addr - WW'(8);
      S_F1:   begin we = 1'b1; waddr = req_addr - WW'(8); wdata = rsz_t; end
      S_F2:   raddr = req_addr - WW'(8);
      S_F3:   begin we = 1'b1; waddr = req_addr + rsz - WW'(16); wdata = sz; end
      S_M0:   raddr = bp - WW'(16);
      S_M1:   raddr = bp - rsz - WW'(8);
      S_M2:   raddr = p + rsz - WW'(16);
      S_M3:   raddr = bp - WW'(8);
      S_M4:   raddr = bp + rsz - WW'(8);
      S_M5:   raddr = n + rsz - WW'(16);
      S_MA0:  begin we = 1'b1; waddr = bp - WW'(8); wdata = sz; end
      S_MA1:  raddr = bp - WW'(8);
      S_MA2:  begin we = 1'b1; waddr = bp + rsz - WW'(16); wdata = sz; end
      S_MB0:  begin we = 1'b1; waddr = bp + WW'(hs) - WW'(16); wdata = sz; end
      S_MB1:  raddr = bp - WW'(16);
      S_MB2:  begin we = 1'b1; waddr = bp - rsz - WW'(8); wdata = sz; end
      S_MB3:  raddr = bp - WW'(16);
      S_MC0:  begin we = 1'b1; waddr = p - WW'(8); wdata = sz + rsz_t; end
      S_MC1:  raddr = bp - WW'(8);
      S_MC2:  raddr = bp + rsz - WW'(8);
      S_MC3:  begin we = 1'b1; waddr = n + rsz - WW'(16); wdata = sz; end
      S_W0:   raddr = bp - WW'(8);
      S_G0:   begin we = (heap_sum <= WW'(HEAP_BYTES)); waddr = heap_end - WW'(8);
                wdata = gsz[TAG_W-1:0]; end
      S_G1:   raddr = bp - WW'(8);
      S_G2:   begin we = 1'b1; waddr = bp + rsz - WW'(16); wdata = sz; end
      S_G3:   raddr = bp - WW'(8);
      S_G4:   begin we = 1'b1; waddr = bp + rsz - WW'(8); wdata = TAG_ALLOC; end
      S_P0:   raddr = bp - WW'(8);
      S_P1:   begin
                we    = 1'b1;
                waddr = bp - WW'(8);
                if (rsz_t >= asize && (rsz_t - asize) >= TAG_W'(MIN_BLOCK)) begin
                  wdata = asize | TAG_ALLOC;
                end else begin
                  wdata = rsz_t | TAG_ALLOC;
                end
              end
      S_P2:   raddr = bp - WW'(8);
      S_P3:   begin we = 1'b1; waddr = bp + rsz - WW'(16); wdata = asize | TAG_ALLOC; end
      S_P4:   raddr = bp - WW'(8);
      S_P5:   begin we = 1'b1; waddr = bp + rsz - WW'(8); wdata = csize - asize; end
      S_P6:   raddr = n - WW'(8);
      S_P7:   begin we = 1'b1; waddr = n + rsz - WW'(16); wdata = csize - asize; end
      S_P8:   raddr = bp - WW'(8);
      S_P9:   begin we = 1'b1; waddr = bp + rsz - WW'(16); wdata = csize | TAG_ALLOC; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:3]] <= wdata;
    end
    rdata <= mem[raddr[AW-1:3]];
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {6'd0, status, result_address};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_cnt     <= '0;
      chunk_bytes <= CHUNK_W'(INIT_CHUNK);
      heap_end    <= WW'(32 + INIT_CHUNK);
    end else begin
      if (cfg_wen) begin
        chunk_bytes <= cfg_wdata;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + (IW+1)'(1);
          if (clr_cnt == (IW+1)'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req_addr       <= WW'(s_tdata[32:17]);
            asize          <= (s_tdata[16:0] <= REQ_W'(16)) ? TAG_W'(MIN_BLOCK)
                              : ((TAG_W'(s_tdata[16:0]) + TAG_W'(31)) & ~TAG_W'(15));
            bp             <= WW'(16);
            result_address <= '0;
            status         <= ST_OK;
            from_grow      <= 1'b0;
            if (s_tuser) begin
              state <= S_F0;
            end else if (s_tdata[16:0] == '0) begin
              status <= ST_ZERO;
              state  <= S_OUT;
            end else begin
              state <= S_W0;
            end
          end
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        // free: clear alloc bit in header and footer, then merge
        S_F0: state <= S_F1;
        S_F1: begin sz <= rsz_t; state <= S_F2; end
        S_F2: state <= S_F3;
        S_F3: begin bp <= req_addr; state <= S_M0; end
        // merge with free neighbors
        S_M0: state <= S_M1;
        S_M1: begin p <= bp - rsz; state <= S_M2; end
        S_M2: begin psz <= rsz_t; state <= S_M3; end
        S_M3: begin pa <= rdata[0]; state <= S_M4; end
        S_M4: begin hs <= rsz_t; n <= bp + rsz; state <= S_M5; end
        S_M5: begin
          if (pa && rdata[0]) begin
            state <= from_grow ? S_P0 : S_OUT;
          end else if (pa) begin
            sz    <= hs + rsz_t;
            state <= S_MA0;
          end else if (rdata[0]) begin
            sz    <= hs + psz;
            state <= S_MB0;
          end else begin
            // next block's footer size is added in S_MC0
            sz    <= hs + psz;
            state <= S_MC0;
          end
        end
        S_MA0: state <= S_MA1;
        S_MA1: state <= S_MA2;
        S_MA2: state <= from_grow ? S_P0 : S_OUT;
        S_MB0: state <= S_MB1;
        S_MB1: state <= S_MB2;
        S_MB2: state <= S_MB3;
        S_MB3: state <= S_MB4;
        S_MB4: begin
          bp    <= bp - rsz;
          state <= from_grow ? S_P0 : S_OUT;
        end
        S_MC0: begin sz <= sz + rsz_t; state <= S_MC1; end
        S_MC1: state <= S_MC2;
        S_MC2: begin n <= bp + rsz; state <= S_MC3; end
        S_MC3: state <= S_MB3;
        // first-fit walk from the prologue
        S_W0: state <= (bp - WW'(8) < heap_end) ? S_W1 : S_G0;
        S_W1: begin
          if (rsz_t == '0) begin
            state <= S_G0;
          end else if (!rdata[0] && asize <= rsz_t) begin
            state <= S_P0;
          end else begin
            bp    <= bp + rsz;
            state <= S_W0;
          end
        end
        // heap growth
        S_G0: begin
          if (heap_sum > WW'(HEAP_BYTES)) begin
            status <= ST_FULL;
            state  <= S_OUT;
          end else begin
            bp        <= heap_end;
            heap_end  <= heap_sum;
            sz        <= gsz[TAG_W-1:0];
            from_grow <= 1'b1;
            state     <= S_G1;
          end
        end
        S_G1: state <= S_G2;
        S_G2: state <= S_G3;
        S_G3: state <= S_G4;
        S_G4: state <= S_M0;
        // placement, split when the remainder is at least MIN_BLOCK bytes
        S_P0: state <= S_P1;
        S_P1: begin
          csize <= rsz_t;
          if (rsz_t >= asize && (rsz_t - asize) >= TAG_W'(MIN_BLOCK)) begin
            state <= S_P2;
          end else begin
            state <= S_P8;
          end
        end
        S_P2: state <= S_P3;
        S_P3: state <= S_P4;
        S_P4: state <= S_P5;
        S_P5: begin n <= bp + rsz; state <= S_P6; end
        S_P6: state <= S_P7;
        S_P7: begin result_address <= bp[ADDR_W-1:0]; state <= S_OUT; end
        S_P8: state <= S_P9;
        S_P9: begin result_address <= bp[ADDR_W-1:0]; state <= S_OUT; end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
